@@ design/cmh_pkg.sv @@
// Shared types, constants and helpers for the canonical minimizer hash block.
// No dependencies.
`default_nettype none
package cmh_pkg;

  localparam int CFG_W = 7;  // clamped k / w value, holds up to 127

  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;  // prime = 2^40 + 0x1b3
  localparam logic [7:0]  SENTINEL = 8'h5A;       // 'Z'

  typedef enum logic {
    REG_KMER_LEN   = 1'b0,
    REG_WINDOW_LEN = 1'b1
  } cmh_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] k;
    logic [CFG_W-1:0] w;
  } cmh_cfg_t;

  function automatic logic [7:0] complement(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h41, 8'h61: r = 8'h54;  // A a -> T
      8'h54, 8'h74: r = 8'h41;  // T t -> A
      8'h43, 8'h63: r = 8'h47;  // C c -> G
      8'h47, 8'h67: r = 8'h43;  // G g -> C
      default:      r = b;
    endcase
    return r;
  endfunction

  // One FNV-1a step, byte sign-extended; multiply by 2^40 + 0x1b3.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    logic [72:0] p;
    x = h ^ {{56{b[7]}}, b};
    p = x * FNV_PRIME_LO;
    return p[63:0] + {x[23:0], 40'd0};
  endfunction

endpackage
`default_nettype wire

@@ design/cmh_front.sv @@
// Front end: history shift line, read length count, window issue.
// Depends on cmh_pkg.
`default_nettype none
module cmh_front import cmh_pkg::*; #(
  parameter int MAX_K = 32,
  parameter int MAX_W = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cmh_cfg_t                       cfg,
  input  wire logic                           accept,
  input  wire logic [7:0]                     base,
  input  wire logic                           read_start,
  output logic                                job,
  output logic [(MAX_K+MAX_W-1)*8-1:0]        window
);
  localparam int D = MAX_K + MAX_W - 1;
  localparam int SEEN_W = $clog2(MAX_K + MAX_W);

  logic [7:0]        hist [D];
  logic [SEEN_W-1:0] seen, seen_next;
  logic [SEEN_W:0]   len;

  assign len = (SEEN_W+1)'(cfg.k) + (SEEN_W+1)'(cfg.w) - (SEEN_W+1)'(1);

  always_comb begin
    if (read_start) seen_next = SEEN_W'(1);
    else if (seen == {SEEN_W{1'b1}}) seen_next = seen;
    else seen_next = seen + SEEN_W'(1);
  end

  assign job = accept && ({1'b0, seen_next} >= len);

  // window as it stands after this byte shifts in
  always_comb begin
    for (int i = 0; i < D - 1; i++) window[8*i +: 8] = hist[i+1];
    window[8*(D-1) +: 8] = base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < D - 1; i++) hist[i] <= hist[i+1];
      hist[D-1] <= base;
    end
  end
endmodule
`default_nettype wire

@@ design/cmh_queue.sv @@
// Two-entry queue of windows between front and back end.
// Depends on cmh_pkg (style only).
`default_nettype none
module cmh_queue import cmh_pkg::*; #(
  parameter int DW = 504
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire logic [DW-1:0] wdata,
  output logic               full,
  input  wire logic          rd,
  output logic               nonempty,
  output logic [DW-1:0]      rdata
);
  logic [DW-1:0] mem [2];
  logic          wp, rp;
  logic [1:0]    cnt;

  assign full = cnt == 2'd2;
  assign nonempty = cnt != 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

@@ design/cmh_back.sv @@
// Back end: scans the k-mers of one window for both minima, then hashes the
// smaller one a byte per cycle, or drops the window when both tie. Depends on cmh_pkg.
`default_nettype none
module cmh_back import cmh_pkg::*; #(
  parameter int MAX_K = 32,
  parameter int MAX_W = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cmh_cfg_t                       cfg,
  input  wire logic                           q_nonempty,
  input  wire logic [(MAX_K+MAX_W-1)*8-1:0]   q_data,
  output logic                                q_rd,
  output logic                                res_valid,
  output logic [63:0]                         res_hash,
  input  wire logic                           res_take
);
  localparam int D = MAX_K + MAX_W - 1;
  localparam int MKW = (MAX_K > MAX_W) ? MAX_K : MAX_W;
  localparam int CNT_W = $clog2(MKW + 1);
  localparam int SH_W = $clog2(8 * MAX_K + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_ALIGN = 6'b000100,
    ST_CMP   = 6'b001000,
    ST_HASH  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                 state;
  logic [D*8-1:0]         win;
  logic [MAX_K*8-1:0]     fwd, rev, cand_f, cand_r, sent_f, sent_r;
  logic [63:0]            h;
  logic [CNT_W-1:0]       cnt;
  logic [SH_W-1:0]        pad_sh;
  logic                   load_res;

  assign pad_sh = SH_W'((MAX_K - int'(cfg.k)) * 8);

  // k-mer ending at the top of win, big-endian, leading pad bytes zero
  always_comb begin
    for (int a = 0; a < MAX_K; a++) begin
      if (a < MAX_K - int'(cfg.k)) begin
        cand_f[8*(MAX_K-1-a) +: 8] = 8'd0;
        sent_f[8*(MAX_K-1-a) +: 8] = 8'd0;
      end else begin
        cand_f[8*(MAX_K-1-a) +: 8] = win[8*(D-MAX_K+a) +: 8];
        sent_f[8*(MAX_K-1-a) +: 8] = SENTINEL;
      end
      sent_r[8*(MAX_K-1-a) +: 8] = (a < int'(cfg.k)) ? SENTINEL : 8'd0;
    end
    // reverse complement lands left-aligned; pad bytes stay zero
    for (int q = 0; q < MAX_K; q++)
      cand_r[8*(MAX_K-1-q) +: 8] = complement(cand_f[8*q +: 8]);
  end

  assign q_rd = (state == ST_IDLE) && q_nonempty;
  assign load_res = (state == ST_DONE) && (!res_valid || res_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_nonempty) begin
            win <= q_data;
            fwd <= sent_f;
            rev <= sent_r;
            cnt <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cand_f < fwd) fwd <= cand_f;
          if (cand_r < rev) rev <= cand_r;
          win <= win << 8;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(cfg.w - CFG_W'(1))) state <= ST_ALIGN;
        end
        ST_ALIGN: begin
          fwd <= fwd << pad_sh;
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (fwd == rev) begin
            state <= ST_IDLE;
          end else begin
            if (rev < fwd) fwd <= rev;
            h <= FNV_BASIS;
            cnt <= '0;
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          h <= fnv_step(h, fwd[8*MAX_K-1 -: 8]);
          fwd <= fwd << 8;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(cfg.k - CFG_W'(1))) state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_res) begin
            res_hash <= h;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/canonical_minimizer_hash.sv @@
// Channel   Handshake          Payload
// input     push / full        base[7:0], read_start
// result    empty / pop        minimizer_hash[63:0]
// config    APB psel..pready   kmer_len @0x0, window_len @0x4
//
// In the back end a window runs a scan loop over its w k-mers, then a hash
// loop over the k bytes of the smaller minimum; when both minima tie the
// window is dropped with no result.
// Two windows queue between front and back; full rises when both are waiting.
// rst is synchronous; all queues and the result register come up empty.
// Top level; depends on cmh_pkg, cmh_front, cmh_queue, cmh_back.
`default_nettype none
module canonical_minimizer_hash import cmh_pkg::*; #(
  parameter int MAX_K = 32,
  parameter int MAX_W = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  base,
  input  wire logic        read_start,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      minimizer_hash,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int D = MAX_K + MAX_W - 1;

  logic [5:0]      kmer_len, window_len;
  cmh_cfg_t        cfg;
  logic            accept, job, q_full, q_rd, q_ne, res_valid;
  logic [D*8-1:0]  window, q_data;
  cmh_reg_t        sel;

  assign sel = cmh_reg_t'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= 6'd15;
      window_len <= 6'd10;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_KMER_LEN:   kmer_len <= pwdata[5:0];
        REG_WINDOW_LEN: window_len <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_KMER_LEN:   prdata = {26'd0, kmer_len};
      REG_WINDOW_LEN: prdata = {26'd0, window_len};
      default:        prdata = 32'd0;
    endcase
  end

  // zero acts as 1, anything above the maximum as the maximum
  always_comb begin
    if (kmer_len == 6'd0) cfg.k = CFG_W'(1);
    else if (int'(kmer_len) > MAX_K) cfg.k = CFG_W'(MAX_K);
    else cfg.k = CFG_W'(kmer_len);
    if (window_len == 6'd0) cfg.w = CFG_W'(1);
    else if (int'(window_len) > MAX_W) cfg.w = CFG_W'(MAX_W);
    else cfg.w = CFG_W'(window_len);
  end

  assign full = q_full;
  assign accept = push && !q_full;
  assign empty = !res_valid;

  cmh_front #(.MAX_K(MAX_K), .MAX_W(MAX_W)) u_front (
    .clk, .rst, .cfg, .accept, .base, .read_start, .job, .window
  );

  cmh_queue #(.DW(D*8)) u_queue (
    .clk, .rst, .wr(job), .wdata(window), .full(q_full),
    .rd(q_rd), .nonempty(q_ne), .rdata(q_data)
  );

  cmh_back #(.MAX_K(MAX_K), .MAX_W(MAX_W)) u_back (
    .clk, .rst, .cfg, .q_nonempty(q_ne), .q_data, .q_rd,
    .res_valid, .res_hash(minimizer_hash), .res_take(pop)
  );
endmodule
`default_nettype wire

@@ design/cmh_checker.sv @@
// Port-level checks for canonical_minimizer_hash, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module cmh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [63:0] minimizer_hash,
  input wire logic        pready
);
  // a waiting item stays put until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(minimizer_hash)) else $error("result changed");
  // no result waiting and the queue not full after reset
  a_reset: assert property (@(posedge clk)
    rst |=> empty && !full) else $error("not empty after reset");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    pready) else $error("pready low");
endmodule

bind canonical_minimizer_hash cmh_checker u_cmh_checker (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .minimizer_hash(minimizer_hash), .pready(pready)
);
`default_nettype wire
